>>> hw/rtl/tsd_pkg.sv
package tsd_pkg;

	localparam int DATA_W        = 32;
	localparam int CFG_W         = 64;
	localparam int CFG_IDX_W     = 3;
	localparam int FRAC_BITS_DEF = 16;
	localparam int SAT_IN_W      = 68;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROW0_A = 3'd0,
		REG_ROW0_B = 3'd1,
		REG_ROW1_A = 3'd2,
		REG_ROW1_B = 3'd3,
		REG_ROW2_A = 3'd4,
		REG_ROW2_B = 3'd5,
		REG_RADII  = 3'd6,
		REG_FLAGS  = 3'd7
	} cfg_idx_t;

	// affine matrix rows and translations, raw two's complement words
	typedef struct packed {
		logic [2:0][2:0][DATA_W-1:0] m;
		logic [2:0][DATA_W-1:0]      t;
	} xform_cfg_t;

	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SAT_IN_W-1:0] v);
		logic signed [SAT_IN_W-1:0] hi;
		logic signed [SAT_IN_W-1:0] lo;
		hi = SAT_IN_W'({1'b0, {(DATA_W-1){1'b1}}});
		lo = -hi - SAT_IN_W'(1);
		if (v > hi) begin
			return hi[DATA_W-1:0];
		end else if (v < lo) begin
			return lo[DATA_W-1:0];
		end
		return v[DATA_W-1:0];
	endfunction

endpackage

>>> hw/rtl/tsd_xform.sv
module tsd_xform #(
	parameter int FRACTION_BITS = tsd_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_vld,
	input  logic signed [tsd_pkg::DATA_W-1:0] x,
	input  logic signed [tsd_pkg::DATA_W-1:0] y,
	input  logic signed [tsd_pkg::DATA_W-1:0] z,
	input  tsd_pkg::xform_cfg_t               xcfg,
	input  logic                              enable,
	output logic                              out_vld,
	output logic signed [tsd_pkg::DATA_W-1:0] ox,
	output logic signed [tsd_pkg::DATA_W-1:0] oy,
	output logic signed [tsd_pkg::DATA_W-1:0] oz
);
	import tsd_pkg::*;

	localparam int PROD_W = 2 * DATA_W;

	logic                      vld_s1;
	logic signed [PROD_W-1:0]  prod_s1 [3][3];
	logic signed [DATA_W-1:0]  pt_s1 [3];
	logic signed [DATA_W-1:0]  res [3];
	logic                      vld_s2;
	logic signed [DATA_W-1:0]  o_s2 [3];

	// stage 1: nine exact products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			prod_s1[i][0] <= $signed(xcfg.m[i][0]) * x;
			prod_s1[i][1] <= $signed(xcfg.m[i][1]) * y;
			prod_s1[i][2] <= $signed(xcfg.m[i][2]) * z;
		end
		pt_s1[0] <= x;
		pt_s1[1] <= y;
		pt_s1[2] <= z;
	end

	// stage 2: floor shift, sum with translation, saturate; the point passes through when enable is low
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			res[i] = sat32(SAT_IN_W'(prod_s1[i][0] >>> FRACTION_BITS)
				+ SAT_IN_W'(prod_s1[i][1] >>> FRACTION_BITS)
				+ SAT_IN_W'(prod_s1[i][2] >>> FRACTION_BITS)
				+ SAT_IN_W'($signed(xcfg.t[i])));
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			o_s2[i] <= enable ? res[i] : pt_s1[i];
		end
	end

	assign out_vld = vld_s2;
	assign ox      = o_s2[0];
	assign oy      = o_s2[1];
	assign oz      = o_s2[2];

endmodule

>>> hw/rtl/tsd_sqrt.sv
module tsd_sqrt #(
	parameter int RAD_W  = 64,
	parameter int SIDE_W = 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_vld,
	input  logic [RAD_W-1:0]     rad_in,
	input  logic [SIDE_W-1:0]    side_in,
	output logic                 out_vld,
	output logic [RAD_W/2-1:0]   root_out,
	output logic [SIDE_W-1:0]    side_out
);
	localparam int N = RAD_W / 2;

	logic              vld_s  [N];
	logic [RAD_W-1:0]  rad_s  [N];
	logic [N+1:0]      rem_s  [N];
	logic [N-1:0]      root_s [N];
	logic [SIDE_W-1:0] side_s [N];

	// one result bit per stage, restoring digit recurrence
	for (genvar k = 0; k < N; k++) begin : g_stage
		logic              pv;
		logic [RAD_W-1:0]  prad;
		logic [N+1:0]      prem;
		logic [N-1:0]      proot;
		logic [SIDE_W-1:0] pside;
		logic [N+1:0]      cur;
		logic [N+1:0]      trial;
		logic              ge;

		if (k == 0) begin : g_first
			assign pv    = in_vld;
			assign prad  = rad_in;
			assign prem  = '0;
			assign proot = '0;
			assign pside = side_in;
		end else begin : g_next
			assign pv    = vld_s[k-1];
			assign prad  = rad_s[k-1];
			assign prem  = rem_s[k-1];
			assign proot = root_s[k-1];
			assign pside = side_s[k-1];
		end

		assign cur   = {prem[N-1:0], prad[RAD_W-1 -: 2]};
		assign trial = {proot, 2'b01};
		assign ge    = (cur >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			rad_s[k]  <= prad << 2;
			rem_s[k]  <= ge ? cur - trial : cur;
			root_s[k] <= {proot[N-2:0], ge};
			side_s[k] <= pside;
		end
	end

	assign out_vld  = vld_s[N-1];
	assign root_out = root_s[N-1];
	assign side_out = side_s[N-1];

	// floor root leaves a remainder no larger than twice the root
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[N-1] |-> (rem_s[N-1] <= {1'b0, root_s[N-1], 1'b0}))
		else $error("sqrt remainder out of range");

endmodule

>>> hw/rtl/torus_signed_distance.sv
// Torus signed distance, one query point per cycle.
//
// Command channel: a point (px, py, pz, signed Q16.16) is taken on a clock
// edge where start is high and busy is low. busy never rises, so a new point
// may be issued every cycle. Each point yields exactly one result: distance
// is valid for one cycle while done is high, in issue order. The receiver
// cannot stall; results must be taken when done is shown.
//
// The pipeline runs the affine transform, squaring and the sum, the first
// root (one bit per stage), the radius offset, square and sum, the second
// root and the final offset, optional negation and clamp, in that order.
// Throughput is one point per cycle throughout.
//
// Configuration: cfg_we writes cfg_wdata into register cfg_addr. Write
// only while no point is in flight. Reset clears the pipeline valid bits
// and loads the identity transform, zero radii and clear flags.
module torus_signed_distance #(
	parameter int FRACTION_BITS = tsd_pkg::FRAC_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic signed [tsd_pkg::DATA_W-1:0]    px,
	input  logic signed [tsd_pkg::DATA_W-1:0]    py,
	input  logic signed [tsd_pkg::DATA_W-1:0]    pz,
	output logic                                 done,
	output logic signed [tsd_pkg::DATA_W-1:0]    distance,
	input  logic                                 cfg_we,
	input  logic [tsd_pkg::CFG_IDX_W-1:0]        cfg_addr,
	input  logic [tsd_pkg::CFG_W-1:0]            cfg_wdata
);
	import tsd_pkg::*;

	localparam int SQ_W = 2 * DATA_W;

	logic [CFG_W-1:0] row_a_q [3];
	logic [CFG_W-1:0] row_b_q [3];
	logic [CFG_W-1:0] radii_q;
	logic [1:0]       flags_q;
	xform_cfg_t       xcfg;

	logic                     xf_vld;
	logic signed [DATA_W-1:0] xf_x, xf_y, xf_z;
	logic [DATA_W-1:0]        xmag, ymag;

	logic                     vld_s3;
	logic [SQ_W-1:0]          sqx_s3, sqy_s3;
	logic signed [DATA_W-1:0] tz_s3;
	logic                     vld_s4;
	logic [SQ_W-1:0]          sum_s4;
	logic signed [DATA_W-1:0] tz_s4;

	logic                     r1_vld;
	logic [DATA_W-1:0]        r1_len;
	logic [DATA_W-1:0]        r1_tz;

	logic                     vld_s5;
	logic [DATA_W-1:0]        qmag_s5, zmag_s5;
	logic                     vld_s6;
	logic [SQ_W-1:0]          sqq_s6, sqz_s6;
	logic                     vld_s7;
	logic [SQ_W+1:0]          sum_s7;

	logic                     r2_vld;
	logic [DATA_W:0]          r2_rad;

	logic                     done_s8;
	logic signed [DATA_W-1:0] dist_s8;

	logic signed [DATA_W:0]   qx;
	logic signed [DATA_W+2:0] dval;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_a_q[0] <= CFG_W'(1) << FRACTION_BITS;
			row_b_q[0] <= '0;
			row_a_q[1] <= CFG_W'(1) << (FRACTION_BITS + DATA_W);
			row_b_q[1] <= '0;
			row_a_q[2] <= '0;
			row_b_q[2] <= CFG_W'(1) << FRACTION_BITS;
			radii_q    <= '0;
			flags_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_addr))
				REG_ROW0_A: row_a_q[0] <= cfg_wdata;
				REG_ROW0_B: row_b_q[0] <= cfg_wdata;
				REG_ROW1_A: row_a_q[1] <= cfg_wdata;
				REG_ROW1_B: row_b_q[1] <= cfg_wdata;
				REG_ROW2_A: row_a_q[2] <= cfg_wdata;
				REG_ROW2_B: row_b_q[2] <= cfg_wdata;
				REG_RADII:  radii_q    <= cfg_wdata;
				REG_FLAGS:  flags_q    <= cfg_wdata[1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			xcfg.m[i][0] = row_a_q[i][DATA_W-1:0];
			xcfg.m[i][1] = row_a_q[i][CFG_W-1:DATA_W];
			xcfg.m[i][2] = row_b_q[i][DATA_W-1:0];
			xcfg.t[i]    = row_b_q[i][CFG_W-1:DATA_W];
		end
	end

	assign busy = 1'b0;

	tsd_xform #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_xform (
		.clk    (clk),
		.arst_n (arst_n),
		.in_vld (start && !busy),
		.x      (px),
		.y      (py),
		.z      (pz),
		.xcfg   (xcfg),
		.enable (flags_q[0]),
		.out_vld(xf_vld),
		.ox     (xf_x),
		.oy     (xf_y),
		.oz     (xf_z)
	);

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			done_s8 <= 1'b0;
		end else begin
			vld_s3  <= xf_vld;
			vld_s4  <= vld_s3;
			vld_s5  <= r1_vld;
			vld_s6  <= vld_s5;
			vld_s7  <= vld_s6;
			done_s8 <= r2_vld;
		end
	end

	// magnitude of -2^31 is 2^31, still fits 32 unsigned bits
	assign xmag = xf_x[DATA_W-1] ? DATA_W'(-xf_x) : DATA_W'(xf_x);
	assign ymag = xf_y[DATA_W-1] ? DATA_W'(-xf_y) : DATA_W'(xf_y);
	assign qx   = $signed({1'b0, r1_len}) - $signed({1'b0, radii_q[DATA_W-1:0]});
	assign dval = $signed({2'b00, r2_rad}) - $signed({3'b000, radii_q[CFG_W-1:DATA_W]});

	always_ff @(posedge clk) begin
		sqx_s3  <= SQ_W'(xmag) * SQ_W'(xmag);
		sqy_s3  <= SQ_W'(ymag) * SQ_W'(ymag);
		tz_s3   <= xf_z;
		sum_s4  <= sqx_s3 + sqy_s3;
		tz_s4   <= tz_s3;
		qmag_s5 <= qx[DATA_W] ? DATA_W'(-qx) : DATA_W'(qx);
		zmag_s5 <= r1_tz[DATA_W-1] ? DATA_W'(-$signed(r1_tz)) : r1_tz;
		sqq_s6  <= SQ_W'(qmag_s5) * SQ_W'(qmag_s5);
		sqz_s6  <= SQ_W'(zmag_s5) * SQ_W'(zmag_s5);
		sum_s7  <= (SQ_W+2)'(sqq_s6) + (SQ_W+2)'(sqz_s6);
		dist_s8 <= sat32(flags_q[1] ? SAT_IN_W'(-dval) : SAT_IN_W'(dval));
	end

	tsd_sqrt #(
		.RAD_W (SQ_W),
		.SIDE_W(DATA_W)
	) u_sqrt_len (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (vld_s4),
		.rad_in  (sum_s4),
		.side_in (tz_s4),
		.out_vld (r1_vld),
		.root_out(r1_len),
		.side_out(r1_tz)
	);

	tsd_sqrt #(
		.RAD_W (SQ_W + 2),
		.SIDE_W(1)
	) u_sqrt_dist (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (vld_s7),
		.rad_in  (sum_s7),
		.side_in (1'b0),
		.out_vld (r2_vld),
		.root_out(r2_rad),
		.side_out()
	);

	assign done     = done_s8;
	assign distance = dist_s8;

	// root is never negative, so the distance never drops below -r
	a_floor_minor: assert property (@(posedge clk) disable iff (!arst_n)
		done && !flags_q[1] && !radii_q[CFG_W-1] |->
		($signed({distance[DATA_W-1], distance}) >= -$signed({1'b0, radii_q[CFG_W-1:DATA_W]})))
		else $error("distance below minus minor radius");

	a_ceil_compl: assert property (@(posedge clk) disable iff (!arst_n)
		done && flags_q[1] && !radii_q[CFG_W-1] |->
		($signed({distance[DATA_W-1], distance}) <= $signed({1'b0, radii_q[CFG_W-1:DATA_W]})))
		else $error("complemented distance above minor radius");

	a_qmag_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s6 |-> (sqq_s6 == SQ_W'($past(qmag_s5)) * SQ_W'($past(qmag_s5))))
		else $error("radius offset square mismatch");

endmodule

>>> bench/tb_torus_signed_distance.sv
`timescale 1ns / 100ps

module tb_torus_signed_distance;
	import tsd_pkg::*;

	localparam int LATENCY = 73;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic signed [DATA_W-1:0] px, py, pz;
	logic done;
	logic signed [DATA_W-1:0] distance;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_addr;
	logic [CFG_W-1:0] cfg_wdata;

	logic [CFG_W-1:0] regs [8];
	logic signed [DATA_W-1:0] distance_q [$];
	int mismatches = 0;

	torus_signed_distance dut (.*);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("status: fail");
		$finish;
	end

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint lane(logic [31:0] w);
		return longint'(signed'(w));
	endfunction

	function automatic longint xform_axis(logic [63:0] ra, logic [63:0] rb,
			longint x, longint y, longint z);
		longint s;
		s = ((lane(ra[31:0]) * x) >>> FRAC_BITS_DEF) + ((lane(ra[63:32]) * y) >>> FRAC_BITS_DEF)
			+ ((lane(rb[31:0]) * z) >>> FRAC_BITS_DEF) + lane(rb[63:32]);
		return clamp32(s);
	endfunction

	function automatic logic [63:0] floor_sqrt(logic [127:0] n);
		logic [63:0] root;
		logic [63:0] cand;
		root = 0;
		for (int b = 32; b >= 0; b--) begin
			cand = root | (64'd1 << b);
			if ({64'd0, cand} * {64'd0, cand} <= n) root = cand;
		end
		return root;
	endfunction

	function automatic logic [127:0] square(longint v);
		logic [127:0] m;
		m = (v < 0) ? 128'(-v) : 128'(v);
		return m * m;
	endfunction

	function automatic logic signed [31:0] torus_distance(logic signed [31:0] x,
			logic signed [31:0] y, logic signed [31:0] z);
		longint tx, ty, tz, qx, d;
		tx = x; ty = y; tz = z;
		if (regs[REG_FLAGS][0]) begin
			tx = xform_axis(regs[REG_ROW0_A], regs[REG_ROW0_B], x, y, z);
			ty = xform_axis(regs[REG_ROW1_A], regs[REG_ROW1_B], x, y, z);
			tz = xform_axis(regs[REG_ROW2_A], regs[REG_ROW2_B], x, y, z);
		end
		qx = longint'(floor_sqrt(square(tx) + square(ty))) - longint'(regs[REG_RADII][31:0]);
		d = longint'(floor_sqrt(square(qx) + square(tz))) - longint'(regs[REG_RADII][63:32]);
		if (regs[REG_FLAGS][1]) d = -d;
		return 32'(clamp32(d));
	endfunction

	always @(posedge clk) begin
		if (done) begin
			if (distance_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected distance %0d", distance);
			end else begin
				if (distance !== distance_q[0]) begin
					mismatches++;
					if (mismatches <= 10)
						$display("distance mismatch: expected %0d got %0d", distance_q[0], distance);
				end
				void'(distance_q.pop_front());
			end
		end
	end

	task automatic pause(int n);
		@(negedge clk);
		start <= 0;
		repeat (n) @(negedge clk);
	endtask

	task automatic send_point(logic signed [31:0] x, logic signed [31:0] y,
			logic signed [31:0] z);
		@(negedge clk);
		start <= 1;
		px <= x; py <= y; pz <= z;
		do @(posedge clk); while (busy);
		distance_q.push_back(torus_distance(x, y, z));
	endtask

	task automatic random_gap();
		int r;
		r = $urandom_range(99);
		if (r < 60) return;
		else if (r < 93) pause($urandom_range(1, 3));
		else pause($urandom_range(15, 50));
	endtask

	// wait for pipeline to empty before touching registers
	task automatic drain();
		pause(0);
		while (distance_q.size() != 0) @(negedge clk);
		repeat (LATENCY + 8) @(negedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [63:0] val);
		@(negedge clk);
		cfg_we <= 1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 0;
		regs[idx] = (idx == REG_FLAGS) ? (val & 64'd3) : val;
	endtask

	function automatic logic [63:0] pack(int lo, int hi);
		return {32'(hi), 32'(lo)};
	endfunction

	task automatic random_points(int n, bit narrow);
		logic signed [31:0] x, y, z;
		repeat (n) begin
			x = $urandom; y = $urandom; z = $urandom;
			if (narrow) begin
				x = x >>> $urandom_range(8, 14);
				y = y >>> $urandom_range(8, 14);
				z = z >>> $urandom_range(8, 14);
			end
			send_point(x, y, z);
			random_gap();
		end
	endtask

	task automatic test_extremes();
		int vals [5] = '{32'sh8000_0000, 32'sh7fff_ffff, 0, -1, 1};
		foreach (vals[i]) send_point(vals[i], vals[(i + 1) % 5], vals[(i + 2) % 5]);
		send_point(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
		send_point(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff);
		drain();
		// complement of the most negative sum
		write_reg(REG_RADII, pack(32'hffff_ffff, 32'hffff_ffff));
		write_reg(REG_FLAGS, 2'b10);
		send_point(0, 0, 0);
		send_point(32'sh8000_0000, 0, 32'sh8000_0000);
		send_point(32'sh0001_0000, 32'sh7fff_ffff, -5);
		drain();
	endtask

	task automatic test_torus_shape();
		write_reg(REG_RADII, pack(3 << 16, 1 << 16));
		write_reg(REG_FLAGS, 2'b00);
		send_point(3 << 16, 0, 0);
		send_point(4 << 16, 0, 0);
		send_point(0, 0, 0);
		send_point(0, -(2 << 16), 1 << 16);
		random_points(300, 1);
		drain();
		write_reg(REG_FLAGS, 2'b10);
		random_points(150, 1);
		drain();
	endtask

	task automatic test_transform();
		write_reg(REG_FLAGS, 2'b01);
		// identity x and y rows with a shift in each axis; the z row keeps only its shift
		write_reg(REG_ROW0_B, pack(0, 1 << 16));
		write_reg(REG_ROW1_B, pack(0, -(2 << 16)));
		write_reg(REG_ROW2_B, pack(0, 5 << 15));
		random_points(200, 1);
		drain();
		for (int i = 0; i < 6; i++) write_reg(cfg_idx_t'(i), {$urandom, $urandom} >>> 0);
		write_reg(REG_RADII, {$urandom, $urandom});
		write_reg(REG_FLAGS, 2'b11);
		random_points(250, 0);
		drain();
		for (int i = 0; i < 6; i++)
			write_reg(cfg_idx_t'(i), pack($urandom_range(0, 1 << 17) - (1 << 16),
				$urandom_range(0, 1 << 17) - (1 << 16)));
		write_reg(REG_RADII, pack($urandom_range(1 << 18), $urandom_range(1 << 17)));
		random_points(300, 1);
		drain();
	endtask

	task automatic test_register_extremes();
		for (int i = 0; i < 7; i++) write_reg(cfg_idx_t'(i), '1);
		write_reg(REG_FLAGS, 2'b01);
		random_points(100, 0);
		drain();
		for (int i = 0; i < 7; i++) write_reg(cfg_idx_t'(i), {32'h8000_0000, 32'h8000_0000});
		write_reg(REG_FLAGS, 2'b11);
		random_points(100, 0);
		drain();
		for (int i = 0; i < 7; i++) write_reg(cfg_idx_t'(i), '0);
		write_reg(REG_FLAGS, 2'b01);
		random_points(50, 0);
		drain();
		for (int i = 0; i < 7; i++) write_reg(cfg_idx_t'(i), {32'h7fff_ffff, 32'h7fff_ffff});
		write_reg(REG_FLAGS, 2'b11);
		random_points(100, 0);
		drain();
	endtask

	initial begin
		arst_n = 0;
		start = 0;
		px = 0; py = 0; pz = 0;
		cfg_we = 0;
		cfg_addr = REG_ROW0_A;
		cfg_wdata = 0;
		regs[REG_ROW0_A] = 64'd65536;
		regs[REG_ROW0_B] = 0;
		regs[REG_ROW1_A] = 64'd1 << 48;
		regs[REG_ROW1_B] = 0;
		regs[REG_ROW2_A] = 0;
		regs[REG_ROW2_B] = 64'd65536;
		regs[REG_RADII] = 0;
		regs[REG_FLAGS] = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		test_extremes();
		test_torus_shape();
		test_transform();
		test_register_extremes();
		drain();
		if (mismatches == 0) $display("status: pass");
		else $display("status: fail");
		$finish;
	end

endmodule
